[rtl/rvm_pkg.sv]
`default_nettype none

package rvm_pkg;

  typedef struct packed {
    logic [9:0] fwd_adc;
    logic [9:0] ref_adc;
  } in_t;

  typedef struct packed {
    logic [31:0] fwd_power_mw;
    logic [31:0] ref_power_mw;
    logic [15:0] vswr;
  } out_t;

  // calibration shared by both detector channels
  typedef struct packed {
    logic        [15:0] slope;  // never zero
    logic signed [15:0] icpt;
  } cal_t;

  // per-item flags and powers riding along the VSWR pipe
  typedef struct packed {
    logic [31:0] pf;
    logic [31:0] pr;
    logic        lowp;
    logic        full;
  } vcar_t;

  typedef enum logic [7:0] {
    REG_SLOPE   = 8'd0,
    REG_ICPT    = 8'd1,
    REG_FWD_OFF = 8'd2,
    REG_REF_OFF = 8'd3
  } reg_idx_t;

  localparam logic [15:0] SLOPE_RST   = 16'd6400;
  localparam logic [15:0] ICPT_RST    = 16'd0;
  localparam logic [11:0] FWD_OFF_RST = 12'd620;
  localparam logic [11:0] REF_OFF_RST = 12'd490;

  localparam int DIV_BITS = 25;
  localparam int EXP_BITS = 16;
  localparam int Q_BITS   = 32;
  localparam int RHO_BITS = 16;

  localparam logic [31:0] LOW_POWER_MW = 32'd100;
  localparam logic [15:0] VSWR_MAX     = 16'hFFFF;

  // log2(10)/10 in Q30, and a bias of 64 in Q46 to keep the product positive
  localparam logic signed [54:0] LOG_K    = 55'sd356689313;
  localparam logic signed [54:0] EXP_BIAS = 55'sh10_0000_0000_0000;
  localparam logic signed [27:0] DBM_CLAMP = 28'sd8388608;
  localparam logic [30:0] EXP_ONE = 31'h4000_0000;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = 64'd0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q30, each root taken from the previous one
  function automatic logic [30:0] r_coef(input int k);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 0; i < k; i++) begin
      r = isqrt_c(r << 30);
    end
    return r[30:0];
  endfunction

endpackage

`default_nettype wire

[rtl/rf_power_and_vswr_meter.sv]
`default_nettype none

// RF power and VSWR meter for a pair of logarithmic detectors. Each input
// transaction carries one forward and one reflected 10-bit ADC count; each
// produces exactly one result with both powers in milliwatts and the VSWR
// in Q8.8 (0 when either power is 100 mW or less, 65535 when reflected
// power reaches forward power). The block is fully pipelined: it accepts a
// transaction every cycle unless the pipe is frozen; each one passes
// through the bit-per-stage slope divider, the sixteen exp2 multiplier
// stages, the power-ratio divider, square root stages and VSWR divider.
// out_stall freezes the whole pipe, and in_stall follows it, while a result
// is held. Configuration writes are always taken (cfg_ready is high) and
// must only be made while no transaction is in flight; index 0 is the slope,
// 1 the intercept, 2 and 3 the forward and reflected offsets, other indexes
// are ignored. A slope of zero acts as one.
module rf_power_and_vswr_meter (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rvm_pkg::in_t     in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rvm_pkg::out_t         out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);

  logic [15:0] slope_r;
  logic [15:0] icpt_r;
  logic [11:0] fwd_off_r;
  logic [11:0] ref_off_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r   <= rvm_pkg::SLOPE_RST;
      icpt_r    <= rvm_pkg::ICPT_RST;
      fwd_off_r <= rvm_pkg::FWD_OFF_RST;
      ref_off_r <= rvm_pkg::REF_OFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rvm_pkg::REG_SLOPE:   slope_r   <= cfg_data;
        rvm_pkg::REG_ICPT:    icpt_r    <= cfg_data;
        rvm_pkg::REG_FWD_OFF: fwd_off_r <= cfg_data[11:0];
        rvm_pkg::REG_REF_OFF: ref_off_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  rvm_pkg::cal_t cal;

  assign cal = '{slope: (slope_r == 16'd0) ? 16'd1 : slope_r,
                 icpt:  $signed(icpt_r)};

  logic en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic        fwd_valid;
  logic        ref_valid;
  logic [31:0] fwd_pw;
  logic [31:0] ref_pw;

  rvm_chan u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .adc       (in_data.fwd_adc),
    .offset    (fwd_off_r),
    .cal       (cal),
    .out_valid (fwd_valid),
    .power     (fwd_pw)
  );

  rvm_chan u_ref (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .adc       (in_data.ref_adc),
    .offset    (ref_off_r),
    .cal       (cal),
    .out_valid (ref_valid),
    .power     (ref_pw)
  );

  rvm_vswr u_vswr (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fwd_valid),
    .pf        (fwd_pw),
    .pr        (ref_pw),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_chan_align: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_valid == ref_valid)
    else $error("forward and reflected channels out of step");

  a_low_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.vswr != 16'd0 |->
      out_data.fwd_power_mw > rvm_pkg::LOW_POWER_MW &&
      out_data.ref_power_mw > rvm_pkg::LOW_POWER_MW)
    else $error("nonzero vswr at low power");

  a_full_refl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fwd_power_mw > rvm_pkg::LOW_POWER_MW &&
    out_data.ref_power_mw > rvm_pkg::LOW_POWER_MW &&
    out_data.ref_power_mw >= out_data.fwd_power_mw |->
      out_data.vswr == rvm_pkg::VSWR_MAX)
    else $error("full reflection not saturated");

  a_vswr_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.vswr != 16'd0 |-> out_data.vswr >= 16'd256)
    else $error("vswr below unity");
`endif

endmodule

`default_nettype wire

[rtl/rvm_chan.sv]
`default_nettype none

module rvm_chan (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [9:0]        adc,
  input  wire logic [11:0]       offset,
  input  wire rvm_pkg::cal_t     cal,
  output logic                   out_valid,
  output logic [31:0]            power
);

  localparam int DB = rvm_pkg::DIV_BITS;
  localparam int EB = rvm_pkg::EXP_BITS;
  localparam logic [6:0] NP_SAT  = 7'd96;
  localparam logic [6:0] NP_DBL  = 7'd95;
  localparam logic [6:0] NP_SHR0 = 7'd94;
  localparam logic [6:0] NP_ZERO = 7'd63;

  // stage A: half-millivolts
  logic               va_r;
  logic signed [13:0] h_r;
  logic        [13:0] adc5;
  logic        [13:0] off2;

  assign adc5 = {2'b00, adc, 2'b00} + {4'b0000, adc};
  assign off2 = {1'b0, offset, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      h_r  <= $signed(adc5 - off2);
    end
  end

  // stage B: magnitude, quotient range check, divider setup
  logic          dv_r  [0:DB];
  logic [15:0]   rem_r [0:DB];
  logic [DB-1:0] q_r   [0:DB];
  logic          neg_r [0:DB];
  logic          ovf_r [0:DB];
  logic [1:0]    lo_r  [0:DB];
  logic [13:0]   habs;
  logic          ovf_nxt;

  assign habs    = h_r[13] ? 14'(-h_r) : 14'(h_r);
  // quotient would reach 2^25: the result clamps whatever the intercept
  assign ovf_nxt = {5'b00000, habs[12:0]} >= {cal.slope, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0]  <= va_r;
      rem_r[0] <= {5'b00000, habs[12:2]};
      q_r[0]   <= '0;
      neg_r[0] <= h_r[13];
      ovf_r[0] <= ovf_nxt;
      lo_r[0]  <= habs[1:0];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DB; j++) begin : g_div
    logic        nbit;
    logic [16:0] t;
    logic        ge;
    logic [15:0] rem_nxt;

    if (j == 0) begin : g_b1
      assign nbit = lo_r[j][1];
    end else if (j == 1) begin : g_b0
      assign nbit = lo_r[j][0];
    end else begin : g_bz
      assign nbit = 1'b0;
    end

    assign t       = {rem_r[j], nbit};
    assign ge      = t >= {1'b0, cal.slope};
    assign rem_nxt = ge ? 16'(t - {1'b0, cal.slope}) : t[15:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1]  <= dv_r[j];
        rem_r[j+1] <= rem_nxt;
        q_r[j+1]   <= {q_r[j][DB-2:0], ge};
        neg_r[j+1] <= neg_r[j];
        ovf_r[j+1] <= ovf_r[j];
        lo_r[j+1]  <= lo_r[j];
      end
    end
  end

  // stage C: signed dBm in Q16 with intercept, clamped
  logic               vc_r;
  logic signed [24:0] dbm_r;
  logic        [25:0] qm;
  logic signed [27:0] sq_pos;
  logic signed [27:0] sq;
  logic signed [27:0] dsum;
  logic signed [27:0] dcl;

  assign qm     = ovf_r[DB] ? 26'h200_0000 : {1'b0, q_r[DB]};
  assign sq_pos = $signed({2'b00, qm});
  assign sq     = neg_r[DB] ? -sq_pos : sq_pos;
  assign dsum   = sq - (28'(cal.icpt) <<< 8);

  always_comb begin
    if (dsum > rvm_pkg::DBM_CLAMP) begin
      dcl = rvm_pkg::DBM_CLAMP;
    end else if (dsum < -rvm_pkg::DBM_CLAMP) begin
      dcl = -rvm_pkg::DBM_CLAMP;
    end else begin
      dcl = dsum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r  <= dv_r[DB];
      dbm_r <= 25'(dcl);
    end
  end

  // stage D: exponent of two, integer part biased by 64
  logic        ve_r  [0:EB];
  logic [30:0] acc_r [0:EB];
  logic [6:0]  np_r  [0:EB];
  logic [15:0] ef_r  [0:EB];
  logic signed [54:0] prod;

  assign prod = 55'(dbm_r) * rvm_pkg::LOG_K + rvm_pkg::EXP_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r[0] <= 1'b0;
    end else if (en) begin
      ve_r[0]  <= vc_r;
      acc_r[0] <= rvm_pkg::EXP_ONE;
      np_r[0]  <= prod[52:46];
      ef_r[0]  <= prod[45:30];
    end
  end

  // 2^f: one constant multiply per fraction bit, MSB first
  for (genvar k = 1; k <= EB; k++) begin : g_exp
    localparam logic [30:0] RK = rvm_pkg::r_coef(k);
    logic [61:0] pm;
    logic [30:0] acc_nxt;

    assign pm      = {31'd0, acc_r[k-1]} * {31'd0, RK};
    assign acc_nxt = ef_r[k-1][EB-k] ? pm[60:30] : acc_r[k-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ve_r[k] <= 1'b0;
      end else if (en) begin
        ve_r[k]  <= ve_r[k-1];
        acc_r[k] <= acc_nxt;
        np_r[k]  <= np_r[k-1];
        ef_r[k]  <= ef_r[k-1];
      end
    end
  end

  // final scale by 2^n
  logic        vo_r;
  logic [31:0] pw_r;
  logic [31:0] pw_nxt;
  logic [6:0]  np;
  logic [30:0] accf;

  assign np   = np_r[EB];
  assign accf = acc_r[EB];

  always_comb begin
    if (np >= NP_SAT) begin
      pw_nxt = 32'hFFFF_FFFF;
    end else if (np == NP_DBL) begin
      pw_nxt = {accf, 1'b0};
    end else if (np <= NP_ZERO) begin
      pw_nxt = 32'd0;
    end else begin
      pw_nxt = {1'b0, accf} >> 5'(NP_SHR0 - np);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= ve_r[EB];
      pw_r <= pw_nxt;
    end
  end

  assign out_valid = vo_r;
  assign power     = pw_r;

endmodule

`default_nettype wire

[rtl/rvm_vswr.sv]
`default_nettype none

module rvm_vswr (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [31:0]   pf,
  input  wire logic [31:0]   pr,
  output logic               out_valid,
  output rvm_pkg::out_t      out_data
);

  localparam int QB = rvm_pkg::Q_BITS;
  localparam int RB = rvm_pkg::RHO_BITS;
  localparam int SQ0 = QB + 1;        // sqrt setup
  localparam int SQN = SQ0 + RB;      // last sqrt step
  localparam int VD0 = SQN + 1;       // VSWR divider setup
  localparam int VDN = VD0 + RB;      // last VSWR divider step

  logic           val_r [0:VDN];
  rvm_pkg::vcar_t car_r [0:VDN];

  // ratio divider pr*2^32/pf
  logic [31:0] rem_r [0:QB];
  logic [31:0] q_r   [0:QB];
  rvm_pkg::vcar_t car_nxt;

  assign car_nxt = '{pf:   pf,
                     pr:   pr,
                     lowp: (pf <= rvm_pkg::LOW_POWER_MW) || (pr <= rvm_pkg::LOW_POWER_MW),
                     full: pr >= pf};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r[0] <= 1'b0;
    end else if (en) begin
      val_r[0] <= in_valid;
      car_r[0] <= car_nxt;
      rem_r[0] <= pr;
      q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_qdiv
    logic [32:0] t;
    logic        ge;
    logic [31:0] rem_nxt;

    assign t       = {rem_r[j], 1'b0};
    assign ge      = t >= {1'b0, car_r[j].pf};
    assign rem_nxt = ge ? 32'(t - {1'b0, car_r[j].pf}) : t[31:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[j+1] <= 1'b0;
      end else if (en) begin
        val_r[j+1] <= val_r[j];
        car_r[j+1] <= car_r[j];
        rem_r[j+1] <= rem_nxt;
        q_r[j+1]   <= {q_r[j][QB-2:0], ge};
      end
    end
  end

  // digit-by-digit square root, two radicand bits per stage
  logic [31:0] sx_r [SQ0:SQN];
  logic [17:0] sr_r [SQ0:SQN];
  logic [15:0] rt_r [SQ0:SQN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r[SQ0] <= 1'b0;
    end else if (en) begin
      val_r[SQ0] <= val_r[QB];
      car_r[SQ0] <= car_r[QB];
      sx_r[SQ0]  <= q_r[QB];
      sr_r[SQ0]  <= '0;
      rt_r[SQ0]  <= '0;
    end
  end

  for (genvar s = 0; s < RB; s++) begin : g_sqrt
    localparam int I = SQ0 + 1 + s;
    logic [19:0] t;
    logic [19:0] trial;
    logic        ge;
    logic [17:0] sr_nxt;

    assign t      = {sr_r[I-1], sx_r[I-1][QB-1-2*s -: 2]};
    assign trial  = {2'b00, rt_r[I-1], 2'b01};
    assign ge     = t >= trial;
    assign sr_nxt = ge ? 18'(t - trial) : t[17:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[I] <= 1'b0;
      end else if (en) begin
        val_r[I] <= val_r[I-1];
        car_r[I] <= car_r[I-1];
        sx_r[I]  <= sx_r[I-1];
        sr_r[I]  <= sr_nxt;
        rt_r[I]  <= {rt_r[I-1][RB-2:0], ge};
      end
    end
  end

  // (1+rho)/(1-rho) in Q8.8 as (65536+rho)*256/(65536-rho)
  logic [16:0] vr_r [VD0:VDN];
  logic [16:0] vd_r [VD0:VDN];
  logic [7:0]  vl_r [VD0:VDN];
  logic [15:0] vq_r [VD0:VDN];
  logic        vo_r [VD0:VDN];
  logic [15:0] rho;
  logic [16:0] den;
  logic        vovf;

  assign rho  = rt_r[SQN];
  assign den  = 17'h1_0000 - {1'b0, rho};
  assign vovf = {8'd0, 1'b1, rho} >= {den, 8'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r[VD0] <= 1'b0;
    end else if (en) begin
      val_r[VD0] <= val_r[SQN];
      car_r[VD0] <= car_r[SQN];
      vr_r[VD0]  <= {8'd0, 1'b1, rho[15:8]};
      vd_r[VD0]  <= den;
      vl_r[VD0]  <= rho[7:0];
      vq_r[VD0]  <= '0;
      vo_r[VD0]  <= vovf;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_vdiv
    localparam int I = VD0 + 1 + j;
    logic        nbit;
    logic [17:0] t;
    logic        ge;
    logic [16:0] vr_nxt;

    if (j < 8) begin : g_lo
      assign nbit = vl_r[I-1][7-j];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign t      = {vr_r[I-1], nbit};
    assign ge     = t >= {1'b0, vd_r[I-1]};
    assign vr_nxt = ge ? 17'(t - {1'b0, vd_r[I-1]}) : t[16:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[I] <= 1'b0;
      end else if (en) begin
        val_r[I] <= val_r[I-1];
        car_r[I] <= car_r[I-1];
        vr_r[I]  <= vr_nxt;
        vd_r[I]  <= vd_r[I-1];
        vl_r[I]  <= vl_r[I-1];
        vq_r[I]  <= {vq_r[I-1][RB-2:0], ge};
        vo_r[I]  <= vo_r[I-1];
      end
    end
  end

  // output register
  logic          ov_r;
  rvm_pkg::out_t od_r;
  logic [15:0]   vswr_nxt;

  always_comb begin
    if (car_r[VDN].lowp) begin
      vswr_nxt = 16'd0;
    end else if (car_r[VDN].full || vo_r[VDN]) begin
      vswr_nxt = rvm_pkg::VSWR_MAX;
    end else begin
      vswr_nxt = vq_r[VDN];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= val_r[VDN];
      od_r <= '{fwd_power_mw: car_r[VDN].pf,
                ref_power_mw: car_r[VDN].pr,
                vswr:         vswr_nxt};
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

`default_nettype wire

[tb/rf_power_and_vswr_meter_test.sv]
`timescale 1ns / 100ps

module rf_power_and_vswr_meter_test;

  localparam logic [7:0] REG_UNUSED = 8'd9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  class meter_scoreboard;
    rvm_pkg::out_t pending[$];
    logic [15:0] slope;
    logic signed [15:0] icpt;
    logic [11:0] fwd_off;
    logic [11:0] ref_off;
    logic [63:0] roots[17];
    int errors;
    int results_seen;

    function new();
      roots[0] = 64'h8000_0000;
      for (int k = 1; k <= 16; k++) roots[k] = root64(roots[k-1] << 30);
      slope = 16'd6400;
      icpt = 16'sd0;
      fwd_off = 12'd620;
      ref_off = 12'd490;
      errors = 0;
      results_seen = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 64'd0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] d);
      case (idx)
        rvm_pkg::REG_SLOPE: slope = d;
        rvm_pkg::REG_ICPT: icpt = d;
        rvm_pkg::REG_FWD_OFF: fwd_off = d[11:0];
        rvm_pkg::REG_REF_OFF: ref_off = d[11:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] power_mw(logic [9:0] adc, logic [11:0] off);
      longint s, ic, h, dbm, prod, n;
      logic [63:0] u, f, acc;
      s = (slope == 0) ? 1 : longint'(slope);
      ic = longint'(icpt);
      h = 5 * longint'(adc) - 2 * longint'(off);
      dbm = (h * 64'sd8388608) / s - ic * 256;
      if (dbm > 64'sd8388608) dbm = 64'sd8388608;
      if (dbm < -64'sd8388608) dbm = -64'sd8388608;
      prod = dbm * 64'sd356689313 + (64'sd64 <<< 46);
      u = prod >> 30;
      n = longint'(u >> 16) - 64;
      f = u & 64'hFFFF;
      acc = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
        if (f[16-k]) acc = (acc * roots[k]) >> 30;
      end
      if (n >= 32) return 32'hFFFF_FFFF;
      if (n >= 30) begin
        acc = acc << (n - 30);
        if (acc > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return acc[31:0];
      end
      if (30 - n >= 63) return 32'd0;
      acc = acc >> (30 - n);
      return acc[31:0];
    endfunction

    function logic [15:0] ratio_vswr(logic [31:0] pf, logic [31:0] pr);
      logic [63:0] q, rho, v;
      if (pf <= 100 || pr <= 100) return 16'd0;
      if (pr >= pf) return 16'hFFFF;
      q = {pr, 32'd0} / {32'd0, pf};
      rho = root64(q);
      if (rho >= 65536) return 16'hFFFF;
      v = ((64'd65536 + rho) << 8) / (64'd65536 - rho);
      if (v > 64'hFFFF) v = 64'hFFFF;
      return v[15:0];
    endfunction

    function void note_input(rvm_pkg::in_t d);
      rvm_pkg::out_t e;
      e.fwd_power_mw = power_mw(d.fwd_adc, fwd_off);
      e.ref_power_mw = power_mw(d.ref_adc, ref_off);
      e.vswr = ratio_vswr(e.fwd_power_mw, e.ref_power_mw);
      pending.push_back(e);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(rvm_pkg::out_t got);
      rvm_pkg::out_t e;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        e = pending.pop_front();
        if (got.fwd_power_mw !== e.fwd_power_mw)
          report($sformatf("fwd_power_mw %0d exp %0d", got.fwd_power_mw, e.fwd_power_mw));
        if (got.ref_power_mw !== e.ref_power_mw)
          report($sformatf("ref_power_mw %0d exp %0d", got.ref_power_mw, e.ref_power_mw));
        if (got.vswr !== e.vswr)
          report($sformatf("vswr %0d exp %0d", got.vswr, e.vswr));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rvm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rvm_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  meter_scoreboard sb = new();
  bit gaps_on = 1;
  int cycles = 0;
  int items_sent = 0;
  int phases_run = 0;

  always #2 clk = ~clk;

  rf_power_and_vswr_meter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rf_power_and_vswr_meter regression: fail");
      $finish;
    end
  end

  // result side: sample pre-edge values, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= gaps_on && ($urandom_range(0, 99) < 9);
  end

  task send_item(logic [9:0] f, logic [9:0] r);
    rvm_pkg::in_t d;
    d.fwd_adc = f;
    d.ref_adc = r;
    while (gaps_on && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(d);
    items_sent++;
  endtask

  task drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task write_cfg(logic [7:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  task set_all(logic [15:0] s, logic [15:0] ic, logic [15:0] fo, logic [15:0] ro);
    drain();
    write_cfg(rvm_pkg::REG_SLOPE, s);
    write_cfg(rvm_pkg::REG_ICPT, ic);
    write_cfg(rvm_pkg::REG_FWD_OFF, fo);
    write_cfg(rvm_pkg::REG_REF_OFF, ro);
    phases_run++;
  endtask

  task random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      else
        // mostly forward above reflected so VSWR gets exercised
        send_item(10'($urandom_range(500, 1023)), 10'($urandom_range(380, 900)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset calibration first
    send_item(10'd0, 10'd0);
    send_item(10'd1023, 10'd1023);
    send_item(10'd1023, 10'd0);
    send_item(10'd0, 10'd1023);
    send_item(10'd800, 10'd600);
    send_item(10'd700, 10'd800);
    send_item(10'd450, 10'd420);
    send_item(10'd900, 10'd900);
    // zero slope acts as one, saturating every large reading
    set_all(16'd0, 16'd0, 16'd0, 16'd0);
    send_item(10'd1023, 10'd1023);
    send_item(10'd0, 10'd0);
    send_item(10'd1, 10'd0);
    // gentlest slope with extreme intercepts
    set_all(16'hFFFF, 16'h8000, 16'd2560, 16'd0);
    send_item(10'd1023, 10'd1023);
    send_item(10'd0, 10'd512);
    set_all(16'hFFFF, 16'h7FFF, 16'd0, 16'd2560);
    send_item(10'd1023, 10'd1023);
    send_item(10'd0, 10'd0);
    // offsets above range and an ignored register index
    set_all(16'd6400, 16'd0, 16'd4095, 16'd4095);
    drain();
    write_cfg(REG_UNUSED, 16'd1);
    send_item(10'd1023, 10'd1000);
    send_item(10'd0, 10'd0);

    set_all(16'd6400, 16'd0, 16'd620, 16'd490);
    gaps_on = 0;
    random_items(60);
    gaps_on = 1;
    random_items(60);
    set_all(16'd1, 16'd0, 16'd0, 16'd0);
    random_items(30);
    set_all(16'd12800, 16'hF000, 16'd1000, 16'd800);
    random_items(50);
    set_all(16'd3200, 16'h0C00, 16'd300, 16'd200);
    random_items(50);
    for (int p = 0; p < 3; p++) begin
      set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      random_items(50);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transactions over %0d calibration sets, %0d results checked",
             items_sent, phases_run, sb.results_seen);
    $display("with random gaps and stalls on both sides and saturating extremes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("rf_power_and_vswr_meter regression: pass");
    end else begin
      $display("rf_power_and_vswr_meter regression: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/rvm_pkg.sv
rtl/rvm_chan.sv
rtl/rvm_vswr.sv
rtl/rf_power_and_vswr_meter.sv
tb/rf_power_and_vswr_meter_test.sv
